// ===== sv/mcfc_pkg.sv =====
// Shared types, widths and codes for the Mohr-Coulomb fracture check.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none
package mcfc_pkg;

  localparam int FRAC_BITS   = 16;
  localparam int ID_BITS_DEF = 20;
  localparam int STRESS_W    = 32;
  localparam int FS_W        = 24;
  localparam int TRIG_W      = 18;
  localparam int KIND_W      = 2;
  localparam int RAD_W       = 2 * STRESS_W;
  localparam int ROOT_W      = STRESS_W;
  localparam int PMAX_W      = STRESS_W + 1;
  localparam int DIFF_W      = STRESS_W + 2;
  localparam int SQD_W       = 2 * (STRESS_W + 1);
  localparam int PSH_W       = ROOT_W + TRIG_W;
  localparam int PCOS_W      = ROOT_W + 1 + TRIG_W;
  localparam int SHM_W       = PSH_W - FRAC_BITS;
  localparam int CT_W        = PCOS_W - FRAC_BITS;
  localparam int NORM_W      = CT_W + 1;
  localparam int PFR_W       = FS_W + NORM_W;
  localparam int FT_W        = PFR_W - FRAC_BITS;
  localparam int LIM_W       = FT_W + 1;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 32;

  localparam logic [CFG_IDX_W-1:0] REG_COHESION = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TENSILE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FRICTION = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SIN      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COS      = 3'd4;

  localparam logic [KIND_W-1:0] KIND_INTACT  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_TENSILE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_SHEAR   = 2'd2;
  localparam logic [KIND_W-1:0] KIND_SKIPPED = 2'd3;

  localparam logic OP_START    = 1'b0;
  localparam logic OP_NEIGHBOR = 1'b1;

  localparam logic [TRIG_W-1:0] SIN_RESET = TRIG_W'(1 << FRAC_BITS);

  typedef struct packed {
    logic capture;
    logic init_start;
    logic set_skip;
    logic mul_ld;
    logic sqrt_go;
    logic pmax_ld;
    logic cmp_ld;
    logic norm_ld;
    logic fric_ld;
    logic class_ld;
    logic set_await;
    logic emit;
  } mcfc_cmd_t;

  typedef struct packed {
    logic op;
    logic unbreakable;
    logic connected;
    logic last_nb;
    logic no_nb;
    logic awaiting;
    logic tensile;
    logic sqrt_done;
  } mcfc_stat_t;

  // Clip a signed difference to the 32-bit output range.
  function automatic logic signed [STRESS_W-1:0] sat_stress(input logic signed [STRESS_W:0] v);
    logic signed [STRESS_W-1:0] res;
    if (v[STRESS_W] != v[STRESS_W-1])
      res = v[STRESS_W] ? {1'b1, {(STRESS_W-1){1'b0}}} : {1'b0, {(STRESS_W-1){1'b1}}};
    else
      res = v[STRESS_W-1:0];
    return res;
  endfunction

endpackage
`default_nettype wire

// ===== sv/mcfc_sqrt.sv =====
// Bit-serial integer square root, two radicand bits per cycle.
// Depends on mcfc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mcfc_sqrt
  import mcfc_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              go,
  input  wire logic [RAD_W-1:0]  radicand,
  output logic                   done,
  output logic [ROOT_W-1:0]      root
);
  localparam int CNT_W = $clog2(ROOT_W);

  logic [RAD_W-1:0]  rad_r;
  logic [ROOT_W:0]   rem_r;
  logic [ROOT_W-1:0] root_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              run_r;
  logic              done_r;
  logic [ROOT_W+2:0] rem_try;
  logic [ROOT_W+2:0] trial;
  logic              take;

  assign rem_try = {rem_r, rad_r[RAD_W-1 -: 2]};
  assign trial   = {1'b0, root_r, 2'b01};
  assign take    = rem_try >= trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        run_r  <= 1'b1;
        cnt_r  <= '0;
        rad_r  <= radicand;
        rem_r  <= '0;
        root_r <= '0;
      end else if (run_r) begin
        rad_r <= {rad_r[RAD_W-3:0], 2'b00};
        if (take) begin
          rem_r  <= (ROOT_W+1)'(rem_try - trial);
          root_r <= {root_r[ROOT_W-2:0], 1'b1};
        end else begin
          rem_r  <= rem_try[ROOT_W:0];
          root_r <= {root_r[ROOT_W-2:0], 1'b0};
        end
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(ROOT_W - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign root = root_r;
endmodule
`default_nettype wire

// ===== sv/mcfc_dp.sv =====
// Datapath: config registers, captured beat, principal stress arithmetic,
// classification, partner selection and result registers. Uses mcfc_pkg, mcfc_sqrt.
`timescale 1ns / 1ps
`default_nettype none
module mcfc_dp
  import mcfc_pkg::*;
#(
  parameter int ID_BITS = ID_BITS_DEF
)(
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire mcfc_cmd_t                  cmd,
  output mcfc_stat_t                      stat,
  input  wire logic                       in_op,
  input  wire logic [ID_BITS-1:0]         in_item_id,
  input  wire logic signed [STRESS_W-1:0] in_sxx,
  input  wire logic signed [STRESS_W-1:0] in_syy,
  input  wire logic signed [STRESS_W-1:0] in_sxy,
  input  wire logic signed [STRESS_W-1:0] in_pos_x,
  input  wire logic signed [STRESS_W-1:0] in_pos_y,
  input  wire logic                       in_unbreakable,
  input  wire logic                       in_connected,
  input  wire logic                       in_last_neighbor,
  input  wire logic                       in_no_neighbors,
  input  wire logic                       cfg_wr,
  input  wire logic [CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [CFG_DATA_W-1:0]      cfg_data,
  output logic                            out_valid,
  output logic [ID_BITS-1:0]              out_particle_id,
  output logic [KIND_W-1:0]               out_broken_kind,
  output logic                            out_partner_valid,
  output logic [ID_BITS-1:0]              out_partner_id,
  output logic signed [STRESS_W-1:0]      out_normal_x,
  output logic signed [STRESS_W-1:0]      out_normal_y
);
  // config
  logic signed [STRESS_W-1:0] coh_r, ten_r;
  logic signed [FS_W-1:0]     fs_r;
  logic signed [TRIG_W-1:0]   sin_r, cos_r;

  // captured beat
  logic                       op_r, unb_r, conn_r, last_r, nonb_r;
  logic [ID_BITS-1:0]         id_r;
  logic signed [STRESS_W-1:0] sxx_r, syy_r, sxy_r, px_r, py_r;

  // particle state
  logic [ID_BITS-1:0]         center_id_r, best_id_r;
  logic signed [STRESS_W-1:0] center_x_r, center_y_r, best_x_r, best_y_r;
  logic signed [PMAX_W-1:0]   center_pmax_r;
  logic [KIND_W-1:0]          fail_kind_r;
  logic                       awaiting_r, best_valid_r;
  logic signed [DIFF_W-1:0]   best_diff_r;

  // working registers
  logic [SQD_W-1:0]           psq_d_r;
  logic [RAD_W-1:0]           psq_s_r;
  logic signed [STRESS_W-1:0] first_r;
  logic signed [PMAX_W-1:0]   pmax_r;
  logic [PSH_W-1:0]           pshear_r;
  logic signed [PCOS_W-1:0]   pcos_r;
  logic [SHM_W-1:0]           shear_mag_r;
  logic signed [NORM_W-1:0]   normal_r;
  logic signed [PFR_W-1:0]    pfric_r;

  // output registers
  logic                       out_valid_r, pv_r;
  logic [ID_BITS-1:0]         pid_r, partner_r;
  logic [KIND_W-1:0]          kind_r;
  logic signed [STRESS_W-1:0] nx_r, ny_r;

  // combinational
  logic signed [STRESS_W:0]   d_s, sum_s;
  logic [STRESS_W:0]          ad;
  logic signed [RAD_W-1:0]    sxy_sq;
  logic [RAD_W-1:0]           radicand;
  logic                       sqrt_done;
  logic [ROOT_W-1:0]          root;
  logic signed [PMAX_W:0]     psum;
  logic signed [PMAX_W-1:0]   pmax_nxt;
  logic [TRIG_W-1:0]          abs_sin;
  logic signed [PCOS_W-1:0]   pcos_nxt;
  logic signed [CT_W-1:0]     cterm;
  logic signed [FT_W-1:0]     fterm;
  logic signed [LIM_W-1:0]    lim;
  logic [LIM_W-1:0]           lim_abs;
  logic                       norm_le0;
  logic [KIND_W-1:0]          kind_nxt;
  logic signed [DIFF_W-1:0]   diff;
  logic                       pv_nxt;

  assign d_s    = {sxx_r[STRESS_W-1], sxx_r} - {syy_r[STRESS_W-1], syy_r};
  assign ad     = d_s[STRESS_W] ? (STRESS_W+1)'(-d_s) : d_s;
  assign sum_s  = {sxx_r[STRESS_W-1], sxx_r} + {syy_r[STRESS_W-1], syy_r};
  assign sxy_sq = sxy_r * sxy_r;
  assign radicand = psq_d_r[SQD_W-1:2] + psq_s_r;

  mcfc_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (cmd.sqrt_go),
    .radicand (radicand),
    .done     (sqrt_done),
    .root     (root)
  );

  assign psum = {{2{first_r[STRESS_W-1]}}, first_r} + {2'b00, root};
  always_comb begin
    if (psum[PMAX_W] != psum[PMAX_W-1])
      pmax_nxt = psum[PMAX_W] ? {1'b1, {(PMAX_W-1){1'b0}}} : {1'b0, {(PMAX_W-1){1'b1}}};
    else
      pmax_nxt = psum[PMAX_W-1:0];
  end

  assign abs_sin  = sin_r[TRIG_W-1] ? TRIG_W'(-sin_r) : sin_r;
  assign pcos_nxt = $signed({1'b0, root}) * cos_r;
  assign cterm    = pcos_r[PCOS_W-1:FRAC_BITS];
  assign fterm    = pfric_r[PFR_W-1:FRAC_BITS];
  assign lim      = LIM_W'(coh_r) - LIM_W'(fterm);
  assign lim_abs  = lim[LIM_W-1] ? LIM_W'(-lim) : lim;
  assign norm_le0 = normal_r[NORM_W-1] || (normal_r == '0);

  always_comb begin
    if ((LIM_W'(shear_mag_r) >= lim_abs) && norm_le0)
      kind_nxt = KIND_SHEAR;
    else if ((pmax_r >= PMAX_W'(ten_r)) && !norm_le0)
      kind_nxt = KIND_TENSILE;
    else
      kind_nxt = KIND_INTACT;
  end

  assign diff   = DIFF_W'(center_pmax_r) - DIFF_W'(pmax_r);
  assign pv_nxt = (fail_kind_r == KIND_TENSILE) && best_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coh_r <= '0;
      ten_r <= '0;
      fs_r  <= '0;
      sin_r <= SIN_RESET;
      cos_r <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_index)
        REG_COHESION: coh_r <= cfg_data;
        REG_TENSILE:  ten_r <= cfg_data;
        REG_FRICTION: fs_r  <= cfg_data[FS_W-1:0];
        REG_SIN:      sin_r <= cfg_data[TRIG_W-1:0];
        REG_COS:      cos_r <= cfg_data[TRIG_W-1:0];
        default: ;
      endcase
    end
  end

  // captured beat and arithmetic pipeline, no reset needed
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r   <= in_op;
      id_r   <= in_item_id;
      sxx_r  <= in_sxx;
      syy_r  <= in_syy;
      sxy_r  <= in_sxy;
      px_r   <= in_pos_x;
      py_r   <= in_pos_y;
      unb_r  <= in_unbreakable;
      conn_r <= in_connected;
      last_r <= in_last_neighbor;
      nonb_r <= in_no_neighbors;
    end
    if (cmd.mul_ld) begin
      psq_d_r <= ad * ad;
      psq_s_r <= sxy_sq;
      first_r <= sum_s[STRESS_W:1];
    end
    if (cmd.pmax_ld) begin
      pmax_r   <= pmax_nxt;
      pshear_r <= root * abs_sin;
      pcos_r   <= pcos_nxt;
    end
    if (cmd.norm_ld) begin
      shear_mag_r <= pshear_r[PSH_W-1:FRAC_BITS];
      normal_r    <= NORM_W'(first_r) - NORM_W'(cterm);
    end
    if (cmd.fric_ld)
      pfric_r <= fs_r * normal_r;
    if (cmd.emit) begin
      pid_r     <= center_id_r;
      kind_r    <= fail_kind_r;
      pv_r      <= pv_nxt;
      partner_r <= pv_nxt ? best_id_r : '0;
      nx_r <= pv_nxt ? sat_stress({center_x_r[STRESS_W-1], center_x_r}
                                  - {best_x_r[STRESS_W-1], best_x_r}) : '0;
      ny_r <= pv_nxt ? sat_stress({best_y_r[STRESS_W-1], best_y_r}
                                  - {center_y_r[STRESS_W-1], center_y_r}) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_id_r   <= '0;
      center_x_r    <= '0;
      center_y_r    <= '0;
      center_pmax_r <= '0;
      fail_kind_r   <= KIND_INTACT;
      best_diff_r   <= {1'b0, {(DIFF_W-1){1'b1}}};
      best_id_r     <= '0;
      best_valid_r  <= 1'b0;
      best_x_r      <= '0;
      best_y_r      <= '0;
      awaiting_r    <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit;
      if (cmd.init_start) begin
        center_id_r  <= id_r;
        center_x_r   <= px_r;
        center_y_r   <= py_r;
        best_diff_r  <= {1'b0, {(DIFF_W-1){1'b1}}};
        best_id_r    <= '0;
        best_valid_r <= 1'b0;
        best_x_r     <= '0;
        best_y_r     <= '0;
        awaiting_r   <= 1'b0;
      end
      if (cmd.set_skip) begin
        fail_kind_r   <= KIND_SKIPPED;
        center_pmax_r <= '0;
      end
      if (cmd.class_ld) begin
        fail_kind_r   <= kind_nxt;
        center_pmax_r <= pmax_r;
      end
      if (cmd.cmp_ld && (!best_valid_r || (diff < best_diff_r))) begin
        best_valid_r <= 1'b1;
        best_diff_r  <= diff;
        best_id_r    <= id_r;
        best_x_r     <= px_r;
        best_y_r     <= py_r;
      end
      if (cmd.set_await)
        awaiting_r <= 1'b1;
      if (cmd.emit)
        awaiting_r <= 1'b0;
    end
  end

  assign stat.op          = op_r;
  assign stat.unbreakable = unb_r;
  assign stat.connected   = conn_r;
  assign stat.last_nb     = last_r;
  assign stat.no_nb       = nonb_r;
  assign stat.awaiting    = awaiting_r;
  assign stat.tensile     = (fail_kind_r == KIND_TENSILE);
  assign stat.sqrt_done   = sqrt_done;

  assign out_valid         = out_valid_r;
  assign out_particle_id   = pid_r;
  assign out_broken_kind   = kind_r;
  assign out_partner_valid = pv_r;
  assign out_partner_id    = partner_r;
  assign out_normal_x      = nx_r;
  assign out_normal_y      = ny_r;
endmodule
`default_nettype wire

// ===== sv/mcfc_ctrl.sv =====
// Sequencer for the fracture check: steps the datapath through each beat.
// Depends on mcfc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mcfc_ctrl
  import mcfc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       start,
  output logic            busy,
  input  wire mcfc_stat_t stat,
  output mcfc_cmd_t       cmd
);
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DECIDE = 4'd1;
  localparam logic [3:0] S_MUL    = 4'd2;
  localparam logic [3:0] S_SQGO   = 4'd3;
  localparam logic [3:0] S_SQRT   = 4'd4;
  localparam logic [3:0] S_PMAX   = 4'd5;
  localparam logic [3:0] S_CMP    = 4'd6;
  localparam logic [3:0] S_NORM   = 4'd7;
  localparam logic [3:0] S_FRIC   = 4'd8;
  localparam logic [3:0] S_CLASS  = 4'd9;
  localparam logic [3:0] S_EMIT   = 4'd10;

  logic [3:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          state_nxt   = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (stat.op == OP_START) begin
          cmd.init_start = 1'b1;
          if (stat.unbreakable) begin
            cmd.set_skip = 1'b1;
            state_nxt    = S_EMIT;
          end else begin
            state_nxt = S_MUL;
          end
        end else if (!stat.awaiting) begin
          state_nxt = S_IDLE;
        end else if (stat.tensile && !stat.unbreakable && stat.connected) begin
          state_nxt = S_MUL;
        end else if (stat.last_nb) begin
          state_nxt = S_EMIT;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_MUL: begin
        cmd.mul_ld = 1'b1;
        state_nxt  = S_SQGO;
      end
      S_SQGO: begin
        cmd.sqrt_go = 1'b1;
        state_nxt   = S_SQRT;
      end
      S_SQRT: begin
        if (stat.sqrt_done)
          state_nxt = S_PMAX;
      end
      S_PMAX: begin
        cmd.pmax_ld = 1'b1;
        state_nxt   = (stat.op == OP_NEIGHBOR) ? S_CMP : S_NORM;
      end
      S_CMP: begin
        cmd.cmp_ld = 1'b1;
        state_nxt  = stat.last_nb ? S_EMIT : S_IDLE;
      end
      S_NORM: begin
        cmd.norm_ld = 1'b1;
        state_nxt   = S_FRIC;
      end
      S_FRIC: begin
        cmd.fric_ld = 1'b1;
        state_nxt   = S_CLASS;
      end
      S_CLASS: begin
        cmd.class_ld = 1'b1;
        if (stat.no_nb) begin
          state_nxt = S_EMIT;
        end else begin
          cmd.set_await = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_EMIT: begin
        cmd.emit  = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n)
      state_r <= S_IDLE;
    else
      state_r <= state_nxt;
  end

  assign busy = (state_r != S_IDLE);
endmodule
`default_nettype wire

// ===== sv/mohr_coulomb_fracture_check.sv =====
// 2D Mohr-Coulomb fracture check, top level: sequencer plus datapath.
// Depends on mcfc_pkg, mcfc_ctrl, mcfc_dp (which holds mcfc_sqrt).
//
// Give a beat with start high while busy is low. A start beat (in_op = 0)
// carries a particle's stress and position; neighbour beats (in_op = 1)
// follow and the last carries in_last_neighbor. Each particle yields at
// most one result, shown on the out_ ports for a single cycle with
// out_valid high; the receiver cannot stall it, so it must take every
// result as it comes. Start beats and eligible neighbours run the
// multiply, the 32-step bit-serial square root (two radicand bits per
// cycle) and the later steps; beats that need no arithmetic (ignored or
// ineligible neighbours, unbreakable particles) go straight to idle or
// to the emit state. A result appears in the cycle after the beat's work
// ends, and a new beat may be given in that cycle.
// Configuration writes (cfg_index 0..4: cohesion, tensile strength,
// friction slope, sin and cos of the plane angle) are always ready and
// should only be issued while idle.
`timescale 1ns / 1ps
`default_nettype none
module mohr_coulomb_fracture_check
  import mcfc_pkg::*;
#(
  parameter int ID_BITS = ID_BITS_DEF
)(
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  // item channel
  input  wire logic                       start,
  output logic                            busy,
  input  wire logic                       in_op,
  input  wire logic [ID_BITS-1:0]         in_item_id,
  input  wire logic signed [STRESS_W-1:0] in_sxx,
  input  wire logic signed [STRESS_W-1:0] in_syy,
  input  wire logic signed [STRESS_W-1:0] in_sxy,
  input  wire logic signed [STRESS_W-1:0] in_pos_x,
  input  wire logic signed [STRESS_W-1:0] in_pos_y,
  input  wire logic                       in_unbreakable,
  input  wire logic                       in_connected,
  input  wire logic                       in_last_neighbor,
  input  wire logic                       in_no_neighbors,
  // result channel
  output logic                            out_valid,
  output logic [ID_BITS-1:0]              out_particle_id,
  output logic [KIND_W-1:0]               out_broken_kind,
  output logic                            out_partner_valid,
  output logic [ID_BITS-1:0]              out_partner_id,
  output logic signed [STRESS_W-1:0]      out_normal_x,
  output logic signed [STRESS_W-1:0]      out_normal_y,
  // configuration write channel
  input  wire logic                       cfg_valid,
  output logic                            cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [CFG_DATA_W-1:0]      cfg_data
);
  mcfc_cmd_t  cmd;
  mcfc_stat_t stat;

  // registers take a write every cycle
  assign cfg_ready = 1'b1;

  mcfc_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  mcfc_dp #(
    .ID_BITS (ID_BITS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .in_op             (in_op),
    .in_item_id        (in_item_id),
    .in_sxx            (in_sxx),
    .in_syy            (in_syy),
    .in_sxy            (in_sxy),
    .in_pos_x          (in_pos_x),
    .in_pos_y          (in_pos_y),
    .in_unbreakable    (in_unbreakable),
    .in_connected      (in_connected),
    .in_last_neighbor  (in_last_neighbor),
    .in_no_neighbors   (in_no_neighbors),
    .cfg_wr            (cfg_valid && cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .out_valid         (out_valid),
    .out_particle_id   (out_particle_id),
    .out_broken_kind   (out_broken_kind),
    .out_partner_valid (out_partner_valid),
    .out_partner_id    (out_partner_id),
    .out_normal_x      (out_normal_x),
    .out_normal_y      (out_normal_y)
  );
endmodule
`default_nettype wire

// ===== verif/mcfc_checker.sv =====
// Watches the item, result and configuration channels of the fracture check,
// predicts each particle's verdict and compares it with the result port.
// Depends on mcfc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mcfc_checker
  import mcfc_pkg::*;
(
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  input  wire logic                       busy,
  input  wire logic                       in_op,
  input  wire logic [19:0]                in_item_id,
  input  wire logic signed [STRESS_W-1:0] in_sxx,
  input  wire logic signed [STRESS_W-1:0] in_syy,
  input  wire logic signed [STRESS_W-1:0] in_sxy,
  input  wire logic signed [STRESS_W-1:0] in_pos_x,
  input  wire logic signed [STRESS_W-1:0] in_pos_y,
  input  wire logic                       in_unbreakable,
  input  wire logic                       in_connected,
  input  wire logic                       in_last_neighbor,
  input  wire logic                       in_no_neighbors,
  input  wire logic                       out_valid,
  input  wire logic [19:0]                out_particle_id,
  input  wire logic [KIND_W-1:0]          out_broken_kind,
  input  wire logic                       out_partner_valid,
  input  wire logic [19:0]                out_partner_id,
  input  wire logic signed [STRESS_W-1:0] out_normal_x,
  input  wire logic signed [STRESS_W-1:0] out_normal_y,
  input  wire logic                       cfg_valid,
  input  wire logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [CFG_DATA_W-1:0]      cfg_data,
  output int                              fail_count,
  output int                              pending
);

  typedef struct packed {
    logic [19:0]          pid;
    logic [KIND_W-1:0]    kind;
    logic                 pvalid;
    logic [19:0]          partner;
    logic signed [31:0]   nx;
    logic signed [31:0]   ny;
  } verdict_t;

  localparam longint PMAX_TOP = 64'sd4294967295;
  localparam longint PMAX_BOT = -64'sd4294967296;
  localparam longint DIFF_TOP = 64'sd8589934591;

  verdict_t verdicts[$];

  // register copies
  longint coh, ten, fric, sin_t, cos_t;
  // particle state
  logic [19:0]   ctr_id, best_id;
  longint        ctr_pmax, ctr_x, ctr_y, best_diff, best_x, best_y;
  logic [KIND_W-1:0] kind_q;
  logic          best_ok, waiting;

  function automatic longint root64(input bit [63:0] v);
    bit [63:0] x, r, b;
    x = v;
    r = 0;
    b = 64'h4000_0000_0000_0000;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return longint'(r);
  endfunction

  function automatic void principal_stress(input logic signed [31:0] sx, sy, sxy,
                                           output longint first, second, pmax);
    longint d, p;
    bit [63:0] ad, rad;
    d = longint'(sx) - longint'(sy);
    ad = (d < 0) ? -d : d;
    rad = ((ad * ad) >> 2) + 64'(longint'(sxy) * longint'(sxy));
    first = (longint'(sx) + longint'(sy)) >>> 1;
    second = root64(rad);
    p = first + second;
    if (p > PMAX_TOP) p = PMAX_TOP;
    if (p < PMAX_BOT) p = PMAX_BOT;
    pmax = p;
  endfunction

  function automatic logic signed [31:0] clip32(input longint v);
    if (v > 64'sd2147483647) return 32'sh7fff_ffff;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  function automatic verdict_t make_verdict(input logic [KIND_W-1:0] k, input logic ok);
    verdict_t v;
    v.pid = ctr_id;
    v.kind = k;
    v.pvalid = ok;
    v.partner = ok ? best_id : '0;
    v.nx = ok ? clip32(ctr_x - best_x) : '0;
    v.ny = ok ? clip32(best_y - ctr_y) : '0;
    return v;
  endfunction

  // append one expected result behind those already waiting
  function automatic void queue_verdict(input verdict_t v);
    verdicts = {verdicts, v};
  endfunction

  function automatic void judge_beat();
    longint first, second, pmax, as, shm, nrm, lim, diff;
    if (in_op == OP_START) begin
      ctr_id = in_item_id;
      ctr_x = longint'(in_pos_x);
      ctr_y = longint'(in_pos_y);
      best_diff = DIFF_TOP;
      best_id = '0;
      best_ok = 1'b0;
      best_x = 0;
      best_y = 0;
      waiting = 1'b0;
      if (in_unbreakable) begin
        kind_q = KIND_SKIPPED;
        ctr_pmax = 0;
        queue_verdict(make_verdict(KIND_SKIPPED, 1'b0));
        return;
      end
      principal_stress(in_sxx, in_syy, in_sxy, first, second, pmax);
      ctr_pmax = pmax;
      as = (sin_t < 0) ? -sin_t : sin_t;
      shm = (second * as) >>> FRAC_BITS;
      nrm = first - ((second * cos_t) >>> FRAC_BITS);
      lim = coh - ((fric * nrm) >>> FRAC_BITS);
      if (lim < 0) lim = -lim;
      if (shm >= lim && nrm <= 0) kind_q = KIND_SHEAR;
      else if (pmax >= ten && nrm > 0) kind_q = KIND_TENSILE;
      else kind_q = KIND_INTACT;
      if (in_no_neighbors) queue_verdict(make_verdict(kind_q, 1'b0));
      else waiting = 1'b1;
      return;
    end
    if (!waiting) return;   // stray neighbour
    if (kind_q == KIND_TENSILE && !in_unbreakable && in_connected) begin
      principal_stress(in_sxx, in_syy, in_sxy, first, second, pmax);
      diff = ctr_pmax - pmax;
      // strict less-than keeps the first of equal candidates
      if (!best_ok || diff < best_diff) begin
        best_ok = 1'b1;
        best_diff = diff;
        best_id = in_item_id;
        best_x = longint'(in_pos_x);
        best_y = longint'(in_pos_y);
      end
    end
    if (in_last_neighbor) begin
      waiting = 1'b0;
      queue_verdict(make_verdict(kind_q, kind_q == KIND_TENSILE && best_ok));
    end
  endfunction

  function automatic void check_field(input string name, input longint exp_v, act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    verdict_t e;
    if (!rst_n) begin
      coh = 0; ten = 0; fric = 0; sin_t = 65536; cos_t = 0;
      ctr_id = '0; ctr_pmax = 0; ctr_x = 0; ctr_y = 0; kind_q = KIND_INTACT;
      best_diff = DIFF_TOP; best_id = '0; best_ok = 1'b0; best_x = 0; best_y = 0;
      waiting = 1'b0;
      verdicts.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_COHESION: coh   = longint'($signed(cfg_data));
          REG_TENSILE:  ten   = longint'($signed(cfg_data));
          REG_FRICTION: fric  = longint'($signed(cfg_data[FS_W-1:0]));
          REG_SIN:      sin_t = longint'($signed(cfg_data[TRIG_W-1:0]));
          REG_COS:      cos_t = longint'($signed(cfg_data[TRIG_W-1:0]));
          default: ;
        endcase
      end
      if (start && !busy) judge_beat();
      if (out_valid) begin
        if (verdicts.size() == 0) begin
          $error("result for particle %0d with none expected", out_particle_id);
          fail_count++;
        end else begin
          e = verdicts.pop_front();
          check_field("particle_id", longint'(e.pid), longint'(out_particle_id));
          check_field("broken_kind", longint'(e.kind), longint'(out_broken_kind));
          check_field("partner_valid", longint'(e.pvalid), longint'(out_partner_valid));
          check_field("partner_id", longint'(e.partner), longint'(out_partner_id));
          check_field("normal_x", longint'(e.nx), longint'(out_normal_x));
          check_field("normal_y", longint'(e.ny), longint'(out_normal_y));
        end
      end
    end
    pending = verdicts.size();
  end

endmodule
`default_nettype wire

// ===== verif/tb.sv =====
// Top of the fracture check testbench: clock, reset, beat and register
// stimulus, verdict. Depends on mcfc_pkg, mohr_coulomb_fracture_check and mcfc_checker.
`timescale 1ns / 1ps
`default_nettype none
module tb;
  import mcfc_pkg::*;

  localparam int LIMIT  = 400000;  // cycles
  localparam int SETTLE = 60;      // longer than the slowest beat

  logic clk, rst_n;
  logic start, busy;
  logic in_op;
  logic [19:0] in_item_id;
  logic signed [STRESS_W-1:0] in_sxx, in_syy, in_sxy, in_pos_x, in_pos_y;
  logic in_unbreakable, in_connected, in_last_neighbor, in_no_neighbors;
  logic out_valid;
  logic [19:0] out_particle_id, out_partner_id;
  logic [KIND_W-1:0] out_broken_kind;
  logic out_partner_valid;
  logic signed [STRESS_W-1:0] out_normal_x, out_normal_y;
  logic cfg_valid, cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int fail_count, pending;

  int cycles = 0;
  int beats = 0;
  bit calm = 0;   // no idling while set

  // register settings for the random phases
  longint cfgs[6][5] = '{
    '{0, 0, 0, 65536, 0},
    '{2147483647, -2147483648, 8388607, 131071, 131071},
    '{-2147483648, 2147483647, -8388608, -131072, -131072},
    '{327680, 131072, 39000, 56756, -32768},
    '{0, -65536, 100000, 0, 65536},
    '{1000, 0, -50000, 65536, -65536}
  };

  mohr_coulomb_fracture_check dut (.*);
  mcfc_checker chk (.*);

  always begin
    clk = 1'b1; #1;
    clk = 1'b0; #1;
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Sender gap: about 24 in 100 beats, unless in the calm stretch.
  task automatic maybe_pause();
    if (!calm && $urandom_range(99) < 24) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  // One beat; returns on the edge that accepted it, start still high.
  task automatic send_beat(input logic op, input logic [19:0] id,
                           input logic signed [31:0] sx, sy, sxy, px, py,
                           input logic unb, con, last, nonb);
    maybe_pause();
    start <= 1'b1;
    in_op <= op; in_item_id <= id;
    in_sxx <= sx; in_syy <= sy; in_sxy <= sxy;
    in_pos_x <= px; in_pos_y <= py;
    in_unbreakable <= unb; in_connected <= con;
    in_last_neighbor <= last; in_no_neighbors <= nonb;
    do @(posedge clk); while (busy);
    beats++;
  endtask

  // Hold off until every expected result is in and the block has settled.
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input longint val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[31:0];
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic load_regs(input longint c, t, f, s, co);
    write_reg(REG_COHESION, c);
    write_reg(REG_TENSILE, t);
    write_reg(REG_FRICTION, f);
    write_reg(REG_SIN, s);
    write_reg(REG_COS, co);
  endtask

  function automatic logic signed [31:0] pick_stress();
    int k;
    k = $urandom_range(9);
    if (k <= 5) return 32'(int'($urandom_range(0, 2097152)) - 1048576);
    if (k <= 8) return $urandom;
    case ($urandom_range(2))
      0: return 32'sh7fff_ffff;
      1: return 32'sh8000_0000;
      default: return '0;
    endcase
  endfunction

  function automatic logic signed [31:0] pick_pos();
    if ($urandom_range(4) == 0) return $urandom;
    return 32'(int'($urandom_range(0, 4194304)) - 2097152);
  endfunction

  // A start beat and its neighbours, with the odd stray or cut-short list.
  task automatic run_particle();
    int nn;
    logic signed [31:0] tx, ty, txy;
    logic cut;
    nn = $urandom_range(0, 5);
    cut = ($urandom_range(19) == 0) && nn > 1;
    send_beat(OP_START, 20'($urandom), pick_stress(), pick_stress(), pick_stress(),
              pick_pos(), pick_pos(), $urandom_range(11) == 0, 1'($urandom),
              1'($urandom), nn == 0);
    tx = pick_stress(); ty = pick_stress(); txy = pick_stress();
    for (int i = 0; i < nn; i++) begin
      if (cut && i == nn - 1) break;   // unless a stray closes the list, the next start drops this particle
      if ($urandom_range(4) != 0) begin
        tx = pick_stress(); ty = pick_stress(); txy = pick_stress();
      end
      send_beat(OP_NEIGHBOR, 20'($urandom), tx, ty, txy, pick_pos(), pick_pos(),
                $urandom_range(9) == 0, $urandom_range(6) != 0, i == nn - 1,
                1'($urandom));
    end
    if ($urandom_range(12) == 0)
      send_beat(OP_NEIGHBOR, 20'($urandom), pick_stress(), pick_stress(), pick_stress(),
                pick_pos(), pick_pos(), 1'($urandom), 1'($urandom), 1'($urandom),
                1'($urandom));
  endtask

  initial begin
    int goal;
    rst_n = 1'b0;
    start = 1'b0; in_op = OP_START; in_item_id = '0;
    in_sxx = '0; in_syy = '0; in_sxy = '0; in_pos_x = '0; in_pos_y = '0;
    in_unbreakable = 1'b0; in_connected = 1'b0;
    in_last_neighbor = 1'b0; in_no_neighbors = 1'b0;
    cfg_valid = 1'b0; cfg_index = REG_COHESION; cfg_data = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, reset register values: shear when mean stress <= 0,
    // tensile when it is positive.
    calm = 1;
    send_beat(OP_START, 20'h00000, 32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff,
              0, 0, 0, 0, 0, 1);
    send_beat(OP_START, 20'hfffff, 0, 0, 0, 32'sh7fff_ffff, 32'sh8000_0000, 1, 1, 1, 0);
    // neighbour with nothing awaited is ignored
    send_beat(OP_NEIGHBOR, 20'h12345, 65536, 65536, 0, 0, 0, 0, 1, 1, 0);
    // tensile: unbreakable and loose neighbours skipped, equal pair keeps the first,
    // extreme positions saturate the normal
    send_beat(OP_START, 20'h00001, 32'sh0010_0000, 32'sh0010_0000, 0,
              32'sh7fff_ffff, 32'sh8000_0000, 0, 0, 0, 0);
    send_beat(OP_NEIGHBOR, 20'h00010, 32'sh0010_0000, 32'sh0010_0000, 0, 0, 0, 1, 1, 0, 0);
    send_beat(OP_NEIGHBOR, 20'h00011, 32'sh0010_0000, 32'sh0010_0000, 0, 0, 0, 0, 0, 0, 0);
    send_beat(OP_NEIGHBOR, 20'h00012, 32'sh0008_0000, 0, 0,
              32'sh8000_0000, 32'sh7fff_ffff, 0, 1, 0, 0);
    send_beat(OP_NEIGHBOR, 20'h00013, 32'sh0008_0000, 0, 0, 0, 0, 0, 1, 1, 0);
    // tensile with no eligible neighbour
    send_beat(OP_START, 20'h00002, 65536, 65536, 0, 0, 0, 0, 0, 0, 0);
    send_beat(OP_NEIGHBOR, 20'h00020, 0, 0, 0, 0, 0, 0, 0, 1, 0);
    // shear: neighbours consumed, no partner
    send_beat(OP_START, 20'h00003, -65536, -65536, 65536, 0, 0, 0, 0, 0, 0);
    send_beat(OP_NEIGHBOR, 20'h00030, 65536, 0, 0, 5, 5, 0, 1, 1, 0);
    // start while awaiting drops the first particle
    send_beat(OP_START, 20'h00004, 65536, 0, 0, 0, 0, 0, 0, 0, 0);
    send_beat(OP_START, 20'h00005, 65536, 0, 0, 0, 0, 0, 0, 0, 1);
    // principal stress overflow
    send_beat(OP_START, 20'h00006, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff,
              0, 0, 0, 0, 0, 0);
    send_beat(OP_NEIGHBOR, 20'h00060, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
              -1, -1, 0, 1, 1, 0);
    calm = 0;

    // Random part over several register settings; the drain between phases
    // also makes the sender wait for every outstanding result.
    for (int p = 0; p < 6; p++) begin
      drain();
      load_regs(cfgs[p][0], cfgs[p][1], cfgs[p][2], cfgs[p][3], cfgs[p][4]);
      calm = (p == 2);
      goal = beats + 72;
      while (beats < goal) run_particle();
    end
    calm = 0;

    drain();
    if (fail_count == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== sim.f =====
sv/mcfc_pkg.sv
sv/mcfc_sqrt.sv
sv/mcfc_dp.sv
sv/mcfc_ctrl.sv
sv/mohr_coulomb_fracture_check.sv
verif/mcfc_checker.sv
verif/tb.sv
